// ----- hw/rtl/scs_pkg.sv -----
// Shared types and constants of the spot candidate selector.
// Used by scs_front, scs_queue, scs_back and spot_candidate_selector_top.
package scs_pkg;

    localparam int LEVEL_W = 8;
    localparam int COUNT_W = 9;
    localparam int Q_DEPTH = 4;
    localparam int KIND_W  = 2;
    localparam logic [LEVEL_W-1:0] MAX_CAND_RESET = 8'd4;

    // Register indexes of the configuration port.
    localparam logic CFG_MAX_CAND = 1'b0;

    typedef enum logic [2:0] {
        ST_MATCHED     = 3'd0,
        ST_ACQUIRED    = 3'd1,
        ST_NONE        = 3'd2,
        ST_UNDECIDABLE = 3'd3,
        ST_TOO_MANY    = 3'd4
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        KIND_CAND      = 2'd0,
        KIND_END_CAND  = 2'd1,
        KIND_END_EMPTY = 2'd2
    } t_kind;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

endpackage

// ----- hw/rtl/scs_front.sv -----
// Front end: takes input words, classifies them and pushes useful ones.
// Depends on scs_pkg; feeds scs_queue.
module scs_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [7:0]            i_intensity,
    input  logic                  i_point_present,
    input  logic                  i_frame_last,
    input  scs_pkg::t_q_flags     i_q_flags,
    output logic                  o_push,
    output logic [scs_pkg::KIND_W+scs_pkg::LEVEL_W+2*COORD_BITS-1:0] o_wdata
);
    import scs_pkg::*;

    t_kind kind;
    logic  useful;

    // An empty marker in the middle of a frame changes nothing, so it is dropped here.
    always_comb begin
        kind   = KIND_CAND;
        useful = 1'b1;
        unique case ({i_point_present, i_frame_last})
            2'b10:   kind = KIND_CAND;
            2'b11:   kind = KIND_END_CAND;
            2'b01:   kind = KIND_END_EMPTY;
            default: useful = 1'b0;
        endcase
    end

    assign o_s_tready = !i_q_flags.full;
    assign o_push     = i_s_tvalid && o_s_tready && useful;
    assign o_wdata    = {kind, i_intensity, i_pos_y, i_pos_x};

endmodule

// ----- hw/rtl/scs_queue.sv -----
// Small FIFO between the front end and the back end.
// Depends on scs_pkg for its depth and flag struct.
module scs_queue #(
    parameter int WIDTH = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_pop,
    output logic [WIDTH-1:0]  o_rdata,
    output scs_pkg::t_q_flags o_flags
);
    import scs_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata       = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_flags.empty = (r_count == '0);

endmodule

// ----- hw/rtl/scs_back.sv -----
// Back end: per-frame nearest and brightest tracking, frame decision,
// failure counters and the output register. Depends on scs_pkg.
module scs_back #(
    parameter int COORD_BITS   = 12,
    parameter int COUNTER_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [scs_pkg::KIND_W+scs_pkg::LEVEL_W+2*COORD_BITS-1:0] i_rdata,
    input  scs_pkg::t_q_flags       i_q_flags,
    output logic                    o_pop,
    input  logic [7:0]              i_max_candidates,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [COORD_BITS-1:0]   o_track_x,
    output logic [COORD_BITS-1:0]   o_track_y,
    output scs_pkg::t_status        o_frame_status,
    output logic [COUNTER_BITS-1:0] o_none_found_count,
    output logic [COUNTER_BITS-1:0] o_undecidable_count,
    output logic [COUNTER_BITS-1:0] o_too_many_count
);
    import scs_pkg::*;

    localparam int C_W = COORD_BITS;
    localparam int D_W = 2 * COORD_BITS + 1;

    // Head of the queue.
    t_kind              kind;
    logic [C_W-1:0]     px, py;
    logic [LEVEL_W-1:0] lvl;
    logic               present, last;

    // Tracked point and per-frame state.
    logic [C_W-1:0]     r_last_x, r_last_y, n_last_x, n_last_y;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [C_W-1:0]     r_near_x, r_near_y, n_near_x, n_near_y;
    logic [D_W-1:0]     r_near_dist, n_near_dist;
    logic [C_W-1:0]     r_bright_x, r_bright_y, n_bright_x, n_bright_y;
    logic [LEVEL_W-1:0] r_bright_lvl, n_bright_lvl;
    logic [COUNTER_BITS-1:0] r_nf_tot, r_ud_tot, r_tm_tot;
    logic [COUNTER_BITS-1:0] n_nf_tot, n_ud_tot, n_tm_tot;

    // Output register.
    logic               r_out_valid;
    logic [C_W-1:0]     r_tx, r_ty, n_tx, n_ty;
    t_status            r_status, n_status;

    logic               slot_free;
    logic [C_W-1:0]     dx, dy;
    logic [2*C_W-1:0]   sq_x, sq_y;
    logic [D_W-1:0]     cand_dist;
    logic [C_W-1:0]     nx, ny, bx, by;
    logic               empty_frame;

    assign {kind, lvl, py, px} = i_rdata;
    assign present = (kind != KIND_END_EMPTY);
    assign last    = (kind != KIND_CAND);

    assign slot_free = !r_out_valid || i_m_tready;
    // A word that ends a frame waits until the output register has room.
    assign o_pop     = !i_q_flags.empty && (!last || slot_free);

    assign dx        = (px > r_last_x) ? px - r_last_x : r_last_x - px;
    assign dy        = (py > r_last_y) ? py - r_last_y : r_last_y - py;
    assign sq_x      = dx * dx;
    assign sq_y      = dy * dy;
    assign cand_dist = {1'b0, sq_x} + {1'b0, sq_y};

    always_comb begin
        n_count      = r_count;
        n_near_x     = r_near_x;
        n_near_y     = r_near_y;
        n_near_dist  = r_near_dist;
        n_bright_x   = r_bright_x;
        n_bright_y   = r_bright_y;
        n_bright_lvl = r_bright_lvl;
        n_last_x     = r_last_x;
        n_last_y     = r_last_y;
        n_nf_tot     = r_nf_tot;
        n_ud_tot     = r_ud_tot;
        n_tm_tot     = r_tm_tot;
        n_tx         = '0;
        n_ty         = '0;
        n_status     = ST_MATCHED;
        nx           = '0;
        ny           = '0;
        bx           = '0;
        by           = '0;

        if (present) begin
            // First nearest wins ties; last brightest wins ties.
            if (r_count == '0 || cand_dist < r_near_dist) begin
                n_near_x    = px;
                n_near_y    = py;
                n_near_dist = cand_dist;
            end
            if (r_count == '0 || lvl >= r_bright_lvl) begin
                n_bright_x   = px;
                n_bright_y   = py;
                n_bright_lvl = lvl;
            end
            if (!(&r_count)) begin
                n_count = r_count + 1'b1;
            end
        end

        empty_frame = (n_count == '0);
        if (!empty_frame && !(r_last_x == '0 && r_last_y == '0)) begin
            nx = n_near_x;
            ny = n_near_y;
        end
        if (!empty_frame) begin
            bx = n_bright_x;
            by = n_bright_y;
        end

        if (n_count > {1'b0, i_max_candidates}) begin
            n_status = ST_TOO_MANY;
            n_tm_tot = (&r_tm_tot) ? r_tm_tot : r_tm_tot + 1'b1;
        end else if (nx == '0 && ny == '0) begin
            // A candidate at the origin counts as no point at all.
            if (bx == '0 && by == '0) begin
                n_status = ST_NONE;
                n_nf_tot = (&r_nf_tot) ? r_nf_tot : r_nf_tot + 1'b1;
            end else begin
                n_status = ST_ACQUIRED;
                n_tx     = bx;
                n_ty     = by;
            end
        end else if (nx != bx || ny != by) begin
            n_status = ST_UNDECIDABLE;
            n_ud_tot = (&r_ud_tot) ? r_ud_tot : r_ud_tot + 1'b1;
        end else begin
            n_status = ST_MATCHED;
            n_tx     = bx;
            n_ty     = by;
        end

        if (last) begin
            n_last_x     = n_tx;
            n_last_y     = n_ty;
            n_count      = '0;
            n_near_x     = '0;
            n_near_y     = '0;
            n_near_dist  = '0;
            n_bright_x   = '0;
            n_bright_y   = '0;
            n_bright_lvl = '0;
        end else begin
            n_nf_tot = r_nf_tot;
            n_ud_tot = r_ud_tot;
            n_tm_tot = r_tm_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_count      <= '0;
            r_near_x     <= '0;
            r_near_y     <= '0;
            r_near_dist  <= '0;
            r_bright_x   <= '0;
            r_bright_y   <= '0;
            r_bright_lvl <= '0;
            r_nf_tot     <= '0;
            r_ud_tot     <= '0;
            r_tm_tot     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_last_x     <= n_last_x;
                r_last_y     <= n_last_y;
                r_count      <= n_count;
                r_near_x     <= n_near_x;
                r_near_y     <= n_near_y;
                r_near_dist  <= n_near_dist;
                r_bright_x   <= n_bright_x;
                r_bright_y   <= n_bright_y;
                r_bright_lvl <= n_bright_lvl;
                r_nf_tot     <= n_nf_tot;
                r_ud_tot     <= n_ud_tot;
                r_tm_tot     <= n_tm_tot;
            end
            if (slot_free) begin
                r_out_valid <= o_pop && last;
            end
        end
    end

    // The counters in the result word are copies taken when the frame ends.
    logic [COUNTER_BITS-1:0] r_nf_out, r_ud_out, r_tm_out;

    always_ff @(posedge i_clk) begin
        if (o_pop && last) begin
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_status <= n_status;
            r_nf_out <= n_nf_tot;
            r_ud_out <= n_ud_tot;
            r_tm_out <= n_tm_tot;
        end
    end

    assign o_m_tvalid          = r_out_valid;
    assign o_track_x           = r_tx;
    assign o_track_y           = r_ty;
    assign o_frame_status      = r_status;
    assign o_none_found_count  = r_nf_out;
    assign o_undecidable_count = r_ud_out;
    assign o_too_many_count    = r_tm_out;

`ifndef SYNTHESIS
    a_mid_frame_keeps_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !last) |=> ($stable(r_last_x) && $stable(r_last_y)))
        else $error("tracked point changed inside a frame");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && last) |=> (r_count == '0 && r_bright_lvl == '0 && r_near_dist == '0))
        else $error("per-frame state not cleared at frame end");

    a_failure_point_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_TOO_MANY || r_status == ST_NONE
                         || r_status == ST_UNDECIDABLE))
        |-> (r_tx == '0 && r_ty == '0))
        else $error("failed frame reports a nonzero point");

    a_result_updates_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && last) |=> (r_last_x == r_tx && r_last_y == r_ty))
        else $error("tracked point differs from reported point");
`endif

endmodule

// ----- hw/rtl/spot_candidate_selector_top.sv -----
// Top level of the spot candidate selector: configuration register,
// front end, queue and back end. Depends on scs_pkg and all scs_ modules.
//
//  Channel   Direction  Handshake                 Word contents
//  s stream  in         i_s_tvalid / o_s_tready   pos_x, pos_y, intensity; tuser, tlast
//  m stream  out        o_m_tvalid / i_m_tready   track point, status, three counters
//  APB       in/out     psel, penable, pready     max_candidates at address 0
//
// One input word is taken per cycle while the queue has room; a frame result
// leaves after its closing word has passed the queue, then the output register.
// The back end handles one queued word per cycle unless held back; the squared-distance
// compare and the frame decision share that cycle. A frame-ending word is held
// back in the queue while the output register holds an untaken result. Reset is synchronous
// and clears the internal counters, the tracked point and the queue, not the result word.
module spot_candidate_selector_top #(
    parameter int COORD_BITS   = 12,
    parameter int COUNTER_BITS = 32,
    localparam int IN_W  = ((2 * COORD_BITS + 8 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 3 + 3 * COUNTER_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // pos_x, pos_y, intensity from bit 0 up
    input  logic [IN_W-1:0]  i_s_tdata,
    // point_present
    input  logic             i_s_tuser,
    // frame_last
    input  logic             i_s_tlast,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // track_x, track_y, frame_status, none_found_count, undecidable_count,
    // too_many_count from bit 0 up
    output logic [OUT_W-1:0] o_m_tdata,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import scs_pkg::*;

    localparam int Q_W = KIND_W + LEVEL_W + 2 * COORD_BITS;

    logic [LEVEL_W-1:0]      r_max_cand;
    logic                    push, pop;
    logic [Q_W-1:0]          q_wdata, q_rdata;
    t_q_flags                q_flags;
    logic [COORD_BITS-1:0]   track_x, track_y;
    t_status                 frame_status;
    logic [COUNTER_BITS-1:0] nf_count, ud_count, tm_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_cand <= MAX_CAND_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_MAX_CAND) begin
            r_max_cand <= pwdata[LEVEL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_MAX_CAND) ? 32'(r_max_cand) : '0;

    scs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_s_tvalid      (i_s_tvalid),
        .o_s_tready      (o_s_tready),
        .i_pos_x         (i_s_tdata[COORD_BITS-1:0]),
        .i_pos_y         (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_intensity     (i_s_tdata[2*COORD_BITS+7:2*COORD_BITS]),
        .i_point_present (i_s_tuser),
        .i_frame_last    (i_s_tlast),
        .i_q_flags       (q_flags),
        .o_push          (push),
        .o_wdata         (q_wdata)
    );

    scs_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (q_wdata),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_flags (q_flags)
    );

    scs_back #(
        .COORD_BITS   (COORD_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_rdata             (q_rdata),
        .i_q_flags           (q_flags),
        .o_pop               (pop),
        .i_max_candidates    (r_max_cand),
        .o_m_tvalid          (o_m_tvalid),
        .i_m_tready          (i_m_tready),
        .o_track_x           (track_x),
        .o_track_y           (track_y),
        .o_frame_status      (frame_status),
        .o_none_found_count  (nf_count),
        .o_undecidable_count (ud_count),
        .o_too_many_count    (tm_count)
    );

    assign o_m_tdata = OUT_W'({tm_count, ud_count, nf_count, frame_status, track_y, track_x});

endmodule
